/* hw/rtl/hbc_pkg.sv */
// ----------------------------------------------------------------------------
// hbc_pkg
// Types, constants and fixed-point helpers for the contact force step.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam int W      = 48;
    localparam int CW     = 47;
    localparam int AW     = 100;
    localparam int BW     = 50;
    localparam int CNTW   = 7;

    typedef logic signed [W-1:0] t_q48;

    localparam t_q48 Q_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_q48 Q_MIN = 48'sh8000_0000_0000;

    localparam logic [2:0] CFG_HERTZ_K   = 3'd0;
    localparam logic [2:0] CFG_YIELD_H   = 3'd1;
    localparam logic [2:0] CFG_YIELD_K   = 3'd2;
    localparam logic [2:0] CFG_TANG_K    = 3'd3;
    localparam logic [2:0] CFG_FRICTION  = 3'd4;
    localparam logic [2:0] CFG_BOND_K    = 3'd5;
    localparam logic [2:0] CFG_BOND_DEC  = 3'd6;
    localparam logic [2:0] CFG_FRACTURE  = 3'd7;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_SQRT,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic          start;
        t_alu_op       op;
        logic [AW-1:0] a;
        logic [BW-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [AW-1:0] res;
    } t_alu_rsp;

    typedef struct packed {
        t_q48 overlap;
        t_q48 slide_x;
        t_q48 slide_y;
        t_q48 slide_z;
        t_q48 normal_x;
        t_q48 normal_y;
        t_q48 normal_z;
    } t_in_word;

    typedef struct packed {
        t_q48 normal_force;
        t_q48 tang_force_x;
        t_q48 tang_force_y;
        t_q48 tang_force_z;
        t_q48 bond_normal_out;
        t_q48 bond_tang_x_out;
        t_q48 bond_tang_y_out;
        t_q48 bond_tang_z_out;
        logic is_bonded;
        logic is_broken;
    } t_out_word;

    function automatic t_q48 from_mag(input logic neg, input logic [AW-1:0] m);
        t_q48 r;
        if (neg) begin
            if (m >= AW'(Q_MAX) + AW'(1)) r = Q_MIN;
            else                          r = -$signed(m[W-1:0]);
        end else begin
            if (m > AW'(Q_MAX)) r = Q_MAX;
            else                r = $signed(m[W-1:0]);
        end
        return r;
    endfunction

    function automatic t_q48 fin(input logic neg, input logic [AW-1:0] p);
        return from_mag(neg, {24'b0, p[AW-1:24]});
    endfunction

    function automatic logic [W-1:0] mag48(input t_q48 v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    function automatic t_q48 sat52(input logic signed [51:0] v);
        t_q48 r;
        if (v > 52'(Q_MAX))      r = Q_MAX;
        else if (v < 52'(Q_MIN)) r = Q_MIN;
        else                     r = v[W-1:0];
        return r;
    endfunction

    function automatic t_q48 neg48(input t_q48 v);
        return (v == Q_MIN) ? Q_MAX : -v;
    endfunction

endpackage

/* hw/rtl/hbc_alu.sv */
// ----------------------------------------------------------------------------
// hbc_alu
// Bit-serial shared unit: multiply, floor square root and restoring divide,
// one bit or one root digit per cycle.
// ----------------------------------------------------------------------------
module hbc_alu
    import hbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    t_alu_op           r_op;
    logic [CNTW-1:0]   r_cnt;
    logic [AW-1:0]     r_acc;
    logic [AW-1:0]     r_x;
    logic [AW-1:0]     r_y;
    logic [53:0]       r_rem;

    logic [AW-1:0]     w_mul;
    logic [53:0]       w_rs;
    logic [53:0]       w_trial;
    logic              w_sq_ge;
    logic [53:0]       w_rd;
    logic [53:0]       w_dv;
    logic              w_dv_ge;
    logic [CNTW-1:0]   w_last;

    always_comb begin
        w_mul   = r_acc + (r_x[0] ? r_y : '0);
        w_rs    = {r_rem[51:0], r_x[AW-1:AW-2]};
        w_trial = {2'b00, r_acc[BW-1:0], 2'b01};
        w_sq_ge = (w_rs >= w_trial);
        w_rd    = {r_rem[52:0], r_x[AW-1]};
        w_dv    = {4'b0, r_y[BW-1:0]};
        w_dv_ge = (w_rd >= w_dv);
        case (r_op)
            ALU_DIV: w_last = CNTW'(AW - 1);
            default: w_last = CNTW'(BW - 1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_rem  <= '0;
                r_x    <= i_req.a;
                r_y    <= {{(AW-BW){1'b0}}, i_req.b};
            end else if (r_busy) begin
                unique case (r_op)
                    ALU_MUL: begin
                        r_acc <= w_mul;
                        r_y   <= {r_y[AW-2:0], 1'b0};
                        r_x   <= {1'b0, r_x[AW-1:1]};
                    end
                    ALU_SQRT: begin
                        r_rem <= w_sq_ge ? (w_rs - w_trial) : w_rs;
                        r_acc <= {r_acc[AW-2:0], w_sq_ge};
                        r_x   <= {r_x[AW-3:0], 2'b00};
                    end
                    ALU_DIV: begin
                        r_rem <= w_dv_ge ? (w_rd - w_dv) : w_rd;
                        r_acc <= {r_acc[AW-2:0], w_dv_ge};
                        r_x   <= {r_x[AW-2:0], 1'b0};
                    end
                    default: r_acc <= r_acc;
                endcase
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

endmodule

/* hw/rtl/hertz_bonded_contact_force_step.sv */
// ----------------------------------------------------------------------------
// hertz_bonded_contact_force_step
// Hertz contact with Coulomb slip and a Maxwell bond, one contact step a word.
// ----------------------------------------------------------------------------
// One input word is taken at a time; the block is not ready until its result
// word is in the output register. A sequencer drives one bit-serial unit that
// multiplies, takes square roots and divides. A word without contact and
// without an active bond does not use the unit; a contact runs the stick or
// the slip path, and an active bond runs the bond steps after it. The output
// register frees the input side while a result waits.
module hertz_bonded_contact_force_step
    import hbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [CW-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_PSQ, S_PMUL, S_F1, S_F2, S_D, S_PRJ, S_TSQ, S_LEN, S_MF,
        S_KTL, S_NOSLIP, S_SQ1, S_SQ2, S_SQ3, S_BGATE, S_BN1, S_BN2, S_BNSQ,
        S_BT1, S_BT2, S_BTSQ, S_BRT, S_OUT
    } t_state;

    t_state          r_state;
    logic            r_issued;
    logic [1:0]      r_i;

    logic [CW-1:0]   r_kh, r_hy, r_ky, r_kt, r_mu, r_kb, r_dec, r_ff;

    t_q48            r_h, r_dh, r_last, r_f, r_pw, r_tmp, r_d, r_mf, r_bn;
    t_q48            r_sl [3];
    t_q48            r_nv [3];
    t_q48            r_ts [3];
    t_q48            r_ft [3];
    t_q48            r_bt [3];
    logic signed [51:0] r_dacc;
    logic [AW-1:0]   r_sq;
    logic [AW-1:0]   r_q;
    logic [BW-1:0]   r_root;
    logic [BW-1:0]   r_len;
    logic            r_et, r_broken, r_active;
    logic            r_out_valid;
    t_out_word       r_out;

    t_alu_req        w_req;
    t_alu_rsp        w_rsp;
    logic            w_sgn;
    t_q48            w_fin;
    logic            w_lt;
    t_q48            w_x;
    t_q48            w_hmy;
    t_q48            w_t;
    t_q48            w_inc;
    logic signed [51:0] w_crack;

    hbc_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_lt  = (r_h < $signed({1'b0, r_hy}));
    assign w_x   = w_lt ? r_h : $signed({1'b0, r_hy});
    assign w_hmy = r_h - $signed({1'b0, r_hy});

    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = ALU_MUL;
        w_req.a     = '0;
        w_req.b     = '0;
        w_sgn       = 1'b0;
        unique case (r_state)
            S_PSQ: begin
                w_req.op = ALU_SQRT;
                w_req.a  = {28'b0, w_x, 24'b0};
            end
            S_PMUL: begin
                w_req.a = {52'b0, w_x};
                w_req.b = r_root;
            end
            S_F1: begin
                w_req.a = {53'b0, (w_lt ? r_kh : r_ky)};
                w_req.b = {2'b0, (w_lt ? r_pw : w_hmy)};
            end
            S_F2: begin
                w_req.a = {53'b0, r_kh};
                w_req.b = {2'b0, r_pw};
            end
            S_D: begin
                w_req.a = {52'b0, mag48(r_ts[r_i])};
                w_req.b = {2'b0, mag48(r_nv[r_i])};
                w_sgn   = r_ts[r_i][W-1] ^ r_nv[r_i][W-1];
            end
            S_PRJ: begin
                w_req.a = {52'b0, mag48(r_d)};
                w_req.b = {2'b0, mag48(r_nv[r_i])};
                w_sgn   = r_d[W-1] ^ r_nv[r_i][W-1];
            end
            S_TSQ: begin
                w_req.a = {52'b0, mag48(r_ts[r_i])};
                w_req.b = {2'b0, mag48(r_ts[r_i])};
            end
            S_LEN, S_BRT: begin
                w_req.op = ALU_SQRT;
                w_req.a  = r_sq;
            end
            S_MF: begin
                w_req.a = {53'b0, r_mu};
                w_req.b = {2'b0, r_f};
            end
            S_KTL: begin
                w_req.a = {53'b0, r_kt};
                w_req.b = r_len;
            end
            S_NOSLIP: begin
                w_req.a = {53'b0, r_kt};
                w_req.b = {2'b0, mag48(r_ts[r_i])};
                w_sgn   = r_ts[r_i][W-1];
            end
            S_SQ1: begin
                w_req.a = {52'b0, r_mf};
                w_req.b = {2'b0, mag48(r_ts[r_i])};
            end
            S_SQ2: begin
                w_req.op = ALU_DIV;
                w_req.a  = r_q;
                w_req.b  = r_len;
            end
            S_SQ3: begin
                w_req.op = ALU_DIV;
                w_req.a  = {12'b0, r_q[63:0], 24'b0};
                w_req.b  = {3'b0, r_kt};
            end
            S_BN1: begin
                w_req.a = {53'b0, r_kb};
                w_req.b = {2'b0, mag48(r_dh)};
                w_sgn   = r_dh[W-1];
            end
            S_BN2: begin
                w_req.a = {53'b0, r_dec};
                w_req.b = {2'b0, mag48(r_bn)};
                w_sgn   = r_bn[W-1];
            end
            S_BNSQ: begin
                w_req.a = {52'b0, mag48(r_bn)};
                w_req.b = {2'b0, mag48(r_bn)};
            end
            S_BT1: begin
                w_req.a = {53'b0, r_kb};
                w_req.b = {2'b0, mag48(r_sl[r_i])};
                w_sgn   = r_sl[r_i][W-1];
            end
            S_BT2: begin
                w_req.a = {53'b0, r_dec};
                w_req.b = {2'b0, mag48(r_bt[r_i])};
                w_sgn   = r_bt[r_i][W-1];
            end
            S_BTSQ: begin
                w_req.a = {52'b0, mag48(r_bt[r_i])};
                w_req.b = {2'b0, mag48(r_bt[r_i])};
            end
            default: w_req.op = ALU_MUL;
        endcase
        if (r_state != S_IDLE && r_state != S_BGATE && r_state != S_OUT) begin
            w_req.start = !r_issued;
        end
    end

    assign w_fin   = fin(w_sgn, w_rsp.res);
    assign w_t     = sat52(52'(r_ts[r_i]) - 52'(w_fin));
    assign w_inc   = sat52(52'(r_tmp) - 52'(w_fin));
    assign w_crack = $signed({2'b0, w_rsp.res[BW-1:0]}) - 52'(r_bn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_kh <= '0; r_hy <= '0; r_ky <= '0; r_kt <= '0;
            r_mu <= '0; r_kb <= '0; r_dec <= '0; r_ff <= '0;
            r_last   <= '0;
            r_bn     <= '0;
            r_et     <= 1'b0;
            r_broken <= 1'b0;
            r_active <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_ts[k] <= '0;
                r_bt[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_HERTZ_K:  r_kh  <= i_cfg_data;
                    CFG_YIELD_H:  r_hy  <= i_cfg_data;
                    CFG_YIELD_K:  r_ky  <= i_cfg_data;
                    CFG_TANG_K:   r_kt  <= i_cfg_data;
                    CFG_FRICTION: r_mu  <= i_cfg_data;
                    CFG_BOND_K:   r_kb  <= i_cfg_data;
                    CFG_BOND_DEC: r_dec <= i_cfg_data;
                    CFG_FRACTURE: r_ff  <= i_cfg_data;
                    default:      r_kh  <= r_kh;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_req.start) begin
                r_issued <= 1'b1;
            end
            if (w_rsp.done) begin
                r_issued <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_h     <= i_in.overlap;
                        r_sl[0] <= i_in.slide_x;
                        r_sl[1] <= i_in.slide_y;
                        r_sl[2] <= i_in.slide_z;
                        r_nv[0] <= i_in.normal_x;
                        r_nv[1] <= i_in.normal_y;
                        r_nv[2] <= i_in.normal_z;
                        r_dh    <= sat52(52'(i_in.overlap) - 52'(r_last));
                        r_last  <= i_in.overlap;
                        r_i     <= '0;
                        if (i_in.overlap > 0) begin
                            if (!r_broken) r_et <= 1'b1;
                            r_state <= S_PSQ;
                        end else begin
                            r_f <= '0;
                            for (int k = 0; k < 3; k++) begin
                                r_ts[k] <= '0;
                                r_ft[k] <= '0;
                            end
                            r_state <= S_BGATE;
                        end
                    end
                end
                S_PSQ: if (w_rsp.done) begin
                    r_root  <= w_rsp.res[BW-1:0];
                    r_state <= S_PMUL;
                end
                S_PMUL: if (w_rsp.done) begin
                    r_pw    <= w_fin;
                    r_state <= S_F1;
                end
                S_F1: if (w_rsp.done) begin
                    r_dacc <= '0;
                    if (w_lt) begin
                        r_f     <= w_fin[W-1] ? '0 : w_fin;
                        r_state <= S_D;
                    end else begin
                        r_tmp   <= w_fin;
                        r_state <= S_F2;
                    end
                end
                S_F2: if (w_rsp.done) begin
                    r_f     <= sat52(52'(r_tmp) + 52'(w_fin));
                    r_state <= S_D;
                end
                S_D: if (w_rsp.done) begin
                    r_dacc <= r_dacc + 52'(w_fin);
                    if (r_i == 2'd2) begin
                        r_d     <= sat52(r_dacc + 52'(w_fin));
                        r_sq    <= '0;
                        r_i     <= '0;
                        r_state <= S_PRJ;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end
                S_PRJ: if (w_rsp.done) begin
                    r_ts[r_i] <= sat52(52'(w_t) + 52'(r_sl[r_i]));
                    r_state   <= S_TSQ;
                end
                S_TSQ: if (w_rsp.done) begin
                    r_sq <= r_sq + w_rsp.res;
                    if (r_i == 2'd2) begin
                        r_i     <= '0;
                        r_state <= S_LEN;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_PRJ;
                    end
                end
                S_LEN: if (w_rsp.done) begin
                    r_len   <= w_rsp.res[BW-1:0];
                    r_state <= S_MF;
                end
                S_MF: if (w_rsp.done) begin
                    r_mf    <= w_fin;
                    r_state <= S_KTL;
                end
                S_KTL: if (w_rsp.done) begin
                    if (w_rsp.res > {28'b0, r_mf, 24'b0}) r_state <= S_SQ1;
                    else                                   r_state <= S_NOSLIP;
                end
                S_NOSLIP: if (w_rsp.done) begin
                    r_ft[r_i] <= neg48(w_fin);
                    r_i       <= r_i + 2'd1;
                    if (r_i == 2'd2) r_state <= S_BGATE;
                end
                S_SQ1: if (w_rsp.done) begin
                    r_q     <= w_rsp.res;
                    r_state <= S_SQ2;
                end
                S_SQ2: if (w_rsp.done) begin
                    r_q       <= w_rsp.res;
                    r_ft[r_i] <= from_mag(!r_ts[r_i][W-1], w_rsp.res);
                    r_state   <= S_SQ3;
                end
                S_SQ3: if (w_rsp.done) begin
                    r_ts[r_i] <= from_mag(r_ts[r_i][W-1], w_rsp.res);
                    r_i       <= r_i + 2'd1;
                    r_state   <= (r_i == 2'd2) ? S_BGATE : S_SQ1;
                end
                S_BGATE: begin
                    r_i      <= '0;
                    r_active <= r_et && !r_broken && (r_kb != '0);
                    if (r_et && !r_broken && (r_kb != '0)) r_state <= S_BN1;
                    else                                    r_state <= S_OUT;
                end
                S_BN1: if (w_rsp.done) begin
                    r_tmp   <= w_fin;
                    r_state <= S_BN2;
                end
                S_BN2: if (w_rsp.done) begin
                    r_bn    <= sat52(52'(r_bn) + 52'(r_tmp) - 52'(w_fin));
                    r_state <= S_BNSQ;
                end
                S_BNSQ: if (w_rsp.done) begin
                    r_sq    <= w_rsp.res;
                    r_state <= S_BT1;
                end
                S_BT1: if (w_rsp.done) begin
                    r_tmp   <= w_fin;
                    r_state <= S_BT2;
                end
                S_BT2: if (w_rsp.done) begin
                    r_bt[r_i] <= sat52(52'(r_bt[r_i]) - 52'(w_inc));
                    r_state   <= S_BTSQ;
                end
                S_BTSQ: if (w_rsp.done) begin
                    r_sq <= r_sq + {w_rsp.res[AW-3:0], 2'b00};
                    r_i  <= r_i + 2'd1;
                    r_state <= (r_i == 2'd2) ? S_BRT : S_BT1;
                end
                S_BRT: if (w_rsp.done) begin
                    if (w_crack > $signed({4'b0, r_ff, 1'b0})) r_broken <= 1'b1;
                    r_f <= sat52(52'(r_f) + 52'(r_bn));
                    for (int k = 0; k < 3; k++) begin
                        r_ft[k] <= sat52(52'(r_ft[k]) + 52'(r_bt[k]));
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_out_valid) begin
                    r_out.normal_force    <= r_f;
                    r_out.tang_force_x    <= r_ft[0];
                    r_out.tang_force_y    <= r_ft[1];
                    r_out.tang_force_z    <= r_ft[2];
                    r_out.bond_normal_out <= r_bn;
                    r_out.bond_tang_x_out <= r_bt[0];
                    r_out.bond_tang_y_out <= r_bt[1];
                    r_out.bond_tang_z_out <= r_bt[2];
                    r_out.is_bonded       <= r_active;
                    r_out.is_broken       <= r_broken;
                    r_out_valid           <= 1'b1;
                    r_state               <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_ready_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_rsp.busy)
        else $error("input ready while shared unit busy");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy && !w_rsp.done)
        else $error("shared unit started while busy");

    a_broken_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_broken))
        else $error("fracture flag cleared");

endmodule

/* tb/sv/hbc_force_checker.sv */
// ----------------------------------------------------------------------------
// hbc_force_checker
// Watches the config, input and result channels of the contact force step.
// Keeps its own copy of the registers and contact state, predicts each result
// word from every accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
module hbc_force_checker
    import hbc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  t_in_word      i_in,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  t_out_word     i_out,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [CW-1:0] i_cfg_data,
    output int            o_fail_count,
    output int            o_outstanding
);

    localparam longint POS_LIM = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint NEG_LIM = -64'sh0000_8000_0000_0000;

    longint kh, hy, ky, kt, mu, kb, dec, frac;
    longint last_ov, bn;
    longint ts[3];
    longint bt[3];
    bit     touched, broken;

    t_out_word force_q[$];
    t_out_word want, got;
    int        n_fail;
    int        n_pend;

    initial begin
        n_fail = 0;
        n_pend = 0;
        kh = 0; hy = 0; ky = 0; kt = 0; mu = 0; kb = 0; dec = 0; frac = 0;
        last_ov = 0; bn = 0;
        ts = '{0, 0, 0};
        bt = '{0, 0, 0};
        touched = 0;
        broken = 0;
    end

    assign o_fail_count  = n_fail;
    assign o_outstanding = n_pend;

    function automatic logic [127:0] umul(longint unsigned a, longint unsigned b);
        return {64'd0, a} * {64'd0, b};
    endfunction

    function automatic longint unsigned isqrt(logic [127:0] n);
        longint unsigned r, c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (umul(c, c) <= n) r = c;
        end
        return r;
    endfunction

    function automatic longint unsigned magn(longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint clamp_mag(bit neg, logic [127:0] m);
        if (neg) begin
            if (m >= 128'h8000_0000_0000) return NEG_LIM;
            return -longint'(m[63:0]);
        end
        if (m > 128'h7FFF_FFFF_FFFF) return POS_LIM;
        return longint'(m[63:0]);
    endfunction

    function automatic longint sat48(longint v);
        if (v > POS_LIM) return POS_LIM;
        if (v < NEG_LIM) return NEG_LIM;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic [127:0] p;
        p = umul(magn(a), magn(b)) >> 24;
        return clamp_mag((a < 0) != (b < 0), p);
    endfunction

    function automatic longint pow_three_halves(longint x);
        logic [127:0] sh;
        sh = {64'd0, x} << 24;
        return qmul(x, longint'(isqrt(sh)));
    endfunction

    task automatic contact_step(input t_in_word w, output t_out_word r);
        longint       h, dh, f, d, mf, root, inc;
        longint       sl[3], nv[3], ft[3];
        logic [127:0] sq, acc, q, t2;
        longint unsigned len;
        bit           active, neg;
        h = longint'(w.overlap);
        sl = '{longint'(w.slide_x), longint'(w.slide_y), longint'(w.slide_z)};
        nv = '{longint'(w.normal_x), longint'(w.normal_y), longint'(w.normal_z)};
        ft = '{0, 0, 0};
        dh = sat48(h - last_ov);
        last_ov = h;
        f = 0;
        if (h > 0) begin
            if (!broken) touched = 1;
            if (h < hy) f = qmul(kh, pow_three_halves(h));
            else        f = sat48(qmul(ky, h - hy) + qmul(kh, pow_three_halves(hy)));
            if (f < 0) f = 0;
            d = sat48(qmul(ts[0], nv[0]) + qmul(ts[1], nv[1]) + qmul(ts[2], nv[2]));
            sq = 0;
            for (int i = 0; i < 3; i++) begin
                ts[i] = sat48(ts[i] - qmul(d, nv[i]));
                ts[i] = sat48(ts[i] + sl[i]);
                sq = sq + umul(magn(ts[i]), magn(ts[i]));
            end
            len = isqrt(sq);
            mf = qmul(mu, f);
            if (umul(kt, len) > ({64'd0, mf} << 24)) begin
                for (int i = 0; i < 3; i++) begin
                    neg = ts[i] < 0;
                    q = umul(mf, magn(ts[i])) / {64'd0, len};
                    ft[i] = clamp_mag(!neg, q);
                    ts[i] = clamp_mag(neg, ({64'd0, q[63:0]} << 24) / {64'd0, kt});
                end
            end else begin
                for (int i = 0; i < 3; i++) ft[i] = sat48(-qmul(kt, ts[i]));
            end
        end else begin
            ts = '{0, 0, 0};
        end
        active = touched && !broken && kb > 0;
        if (active) begin
            bn = sat48(bn + qmul(kb, dh) - qmul(dec, bn));
            acc = umul(magn(bn), magn(bn));
            for (int i = 0; i < 3; i++) begin
                inc = sat48(qmul(kb, sl[i]) - qmul(dec, bt[i]));
                bt[i] = sat48(bt[i] - inc);
                t2 = umul(magn(bt[i]), magn(bt[i]));
                acc = acc + (t2 << 2);
            end
            root = longint'(isqrt(acc));
            if (root - bn > 2 * frac) broken = 1;
            f = sat48(f + bn);
            for (int i = 0; i < 3; i++) ft[i] = sat48(ft[i] + bt[i]);
        end
        r.normal_force    = 48'(f);
        r.tang_force_x    = 48'(ft[0]);
        r.tang_force_y    = 48'(ft[1]);
        r.tang_force_z    = 48'(ft[2]);
        r.bond_normal_out = 48'(bn);
        r.bond_tang_x_out = 48'(bt[0]);
        r.bond_tang_y_out = 48'(bt[1]);
        r.bond_tang_z_out = 48'(bt[2]);
        r.is_bonded       = active;
        r.is_broken       = broken;
    endtask

    task automatic check_field(string name, logic [W-1:0] e, logic [W-1:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HERTZ_K:  kh   = longint'(i_cfg_data);
                    CFG_YIELD_H:  hy   = longint'(i_cfg_data);
                    CFG_YIELD_K:  ky   = longint'(i_cfg_data);
                    CFG_TANG_K:   kt   = longint'(i_cfg_data);
                    CFG_FRICTION: mu   = longint'(i_cfg_data);
                    CFG_BOND_K:   kb   = longint'(i_cfg_data);
                    CFG_BOND_DEC: dec  = longint'(i_cfg_data);
                    CFG_FRACTURE: frac = longint'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                contact_step(i_in, want);
                force_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out;
                if (force_q.size() == 0) begin
                    $display("%0t: result word with none expected, got %h", $time, got);
                    n_fail++;
                end else begin
                    want = force_q.pop_front();
                    check_field("normal_force", want.normal_force, got.normal_force);
                    check_field("tang_force_x", want.tang_force_x, got.tang_force_x);
                    check_field("tang_force_y", want.tang_force_y, got.tang_force_y);
                    check_field("tang_force_z", want.tang_force_z, got.tang_force_z);
                    check_field("bond_normal_out", want.bond_normal_out,
                                got.bond_normal_out);
                    check_field("bond_tang_x_out", want.bond_tang_x_out,
                                got.bond_tang_x_out);
                    check_field("bond_tang_y_out", want.bond_tang_y_out,
                                got.bond_tang_y_out);
                    check_field("bond_tang_z_out", want.bond_tang_z_out,
                                got.bond_tang_z_out);
                    check_field("is_bonded", W'(want.is_bonded), W'(got.is_bonded));
                    check_field("is_broken", W'(want.is_broken), W'(got.is_broken));
                end
            end
            n_pend = force_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the contact force step: programs the registers in
// several phases, sends directed and random contact words with random gaps
// and receiver stalls, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import hbc_pkg::*;

    localparam logic [W-1:0] ONE = 48'h1_000_000;
    localparam logic [CW-1:0] CFG_ONE = CW'(ONE);
    localparam logic [CW-1:0] CFG_MAX = {CW{1'b1}};

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    t_in_word      i_in = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    t_out_word     o_out;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index = '0;
    logic [CW-1:0] i_cfg_data = '0;

    int fail_count;
    int outstanding;
    bit hold_req = 0;

    always #5 i_clk = ~i_clk;

    hertz_bonded_contact_force_step dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    hbc_force_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out(o_out),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [W-1:0] any_val();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3, 4:    return {{21{v[26]}}, v[26:0]};
            5, 6:    return {{13{v[34]}}, v[34:0]};
            default: return v[W-1:0];
        endcase
    endfunction

    function automatic logic [W-1:0] axis_val();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return ONE;
            1:       return -ONE;
            2:       return '0;
            9:       return any_val();
            default: return {{23{v[24]}}, v[24:0]};
        endcase
    endfunction

    function automatic t_in_word contact_word();
        t_in_word w;
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    w.overlap = -{22'd0, v[25:0]};
            2:       w.overlap = any_val();
            default: w.overlap = {22'd0, v[25:0]};
        endcase
        w.slide_x  = ($urandom_range(0, 4) == 0) ? any_val() : {{28{v[26]}}, v[45:26]};
        w.slide_y  = ($urandom_range(0, 4) == 0) ? any_val() : {{28{v[46]}}, v[63:44]};
        w.slide_z  = ($urandom_range(0, 4) == 0) ? any_val() : {{28{v[3]}}, v[19:0]};
        w.normal_x = axis_val();
        w.normal_y = axis_val();
        w.normal_z = axis_val();
        return w;
    endfunction

    function automatic logic [CW-1:0] cfg_val(logic [CW-1:0] typical);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CFG_MAX;
            2:       return CW'({$urandom, $urandom});
            default: return CW'($urandom_range(0, 3)) * typical + CW'($urandom % 32'h40_0000);
        endcase
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_regs(input logic [CW-1:0] regs[8]);
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= regs[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_words(input int n);
        for (int i = 0; i < n; i++) send_word(contact_word());
        i_in_valid <= 1'b0;
    endtask

    // receiver: short stalls, a few long ones, and a very long hold on request
    initial begin
        int k;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_out_ready <= 1'b0;
                repeat (6000) @(posedge i_clk);
            end else begin
                k = gap_len();
                if (k > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (k) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    initial begin
        #200_000_000;
        $display("hertz_bonded_contact_force_step regression: fail");
        $finish;
    end

    initial begin
        logic [CW-1:0] regs[8];
        t_in_word      w;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: below and above yield, no contact, extremes, odd normals
        regs = '{2 * CFG_ONE, CFG_ONE, 3 * CFG_ONE, CFG_ONE, CFG_ONE / 2, '0, '0, CFG_MAX};
        load_regs(regs);
        for (int i = 0; i < 20; i++) begin
            w = '{ONE / 2, ONE / 16, -ONE / 32, 0, ONE, 0, 0};
            case (i)
                1:  w.overlap = 3 * ONE;
                2:  w.overlap = '0;
                3:  w.overlap = -ONE;
                4:  w.overlap = Q_MAX;
                5:  w.overlap = Q_MIN;
                6:  w.overlap = 48'd1;
                7:  w.overlap = ONE;
                8:  w = '{ONE, Q_MAX, Q_MAX, Q_MAX, 0, ONE, 0};
                9:  w = '{ONE, Q_MIN, Q_MIN, Q_MIN, 0, 0, -ONE};
                10: w = '{ONE, 4 * ONE, 4 * ONE, 0, 0, 0, 0};
                11: w = '{ONE, 0, 0, 0, Q_MAX, Q_MIN, Q_MAX};
                12: w = '{Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN};
                13: w = '{2 * ONE, 8 * ONE, -8 * ONE, 8 * ONE, ONE, ONE, ONE};
                14: w = '{ONE / 4, 0, 0, 0, 0, ONE, 0};
                15: w = '{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                          48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                          48'hAAAA_AAAA_AAAA};
                16: w = '{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                          48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                          48'h5555_5555_5555};
                default: ;
            endcase
            send_word(w);
        end
        i_in_valid <= 1'b0;

        // bond on, fracture threshold at maximum; receiver holds off so the block backs up
        regs = '{2 * CFG_ONE, CFG_ONE, 3 * CFG_ONE, CFG_ONE, CFG_ONE / 2, CFG_ONE / 4,
                 CFG_ONE / 16, CFG_MAX};
        load_regs(regs);
        hold_req = 1;
        random_words(100);

        regs = '{CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX};
        load_regs(regs);
        random_words(80);

        regs = '{default: '0};
        load_regs(regs);
        random_words(60);

        for (int i = 0; i < 8; i++) regs[i] = cfg_val(CFG_ONE);
        regs[7] = CFG_MAX;
        load_regs(regs);
        random_words(100);

        // weak bond: fracture threshold low enough to break
        regs = '{CFG_ONE, 2 * CFG_ONE, CFG_ONE, CFG_ONE, CFG_ONE / 4, CFG_ONE, CFG_ONE / 8,
                 CFG_ONE / 64};
        load_regs(regs);
        random_words(100);

        for (int i = 0; i < 8; i++) regs[i] = cfg_val(4 * CFG_ONE);
        load_regs(regs);
        random_words(100);

        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("hertz_bonded_contact_force_step regression: pass");
        else
            $display("hertz_bonded_contact_force_step regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/hbc_pkg.sv
hw/rtl/hbc_alu.sv
hw/rtl/hertz_bonded_contact_force_step.sv
tb/sv/hbc_force_checker.sv
tb/sv/tb_top.sv
